// ===== rtl/pfsa_pkg.sv =====
`default_nettype none

package pfsa_pkg;

    // Field widths fixed by the channel definitions
    localparam int ADDR_W   = 48;
    localparam int CNT_W    = 17;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // Command codes
    localparam t_cmd CMD_ALLOC  = 2'd0;
    localparam t_cmd CMD_FREE   = 2'd1;
    localparam t_cmd CMD_REGION = 2'd2;

    // Result status codes
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    // Saturation value of the total frame count
    localparam t_cnt TOTAL_MAX = 17'h1FFFF;

endpackage

`default_nettype wire

// ===== rtl/pfsa_if.sv =====
`default_nettype none

// Command channel: one beat is one allocator command
interface pfsa_in_if;
    import pfsa_pkg::*;

    logic  valid;
    logic  ready;
    t_cmd  cmd;
    t_addr address;
    t_addr region_length;
    logic  region_available;

    modport source (output valid, cmd, address, region_length, region_available,
                    input ready);
    modport sink   (input valid, cmd, address, region_length, region_available,
                    output ready);
endinterface

// Result channel: one beat per command
interface pfsa_out_if;
    import pfsa_pkg::*;

    logic    valid;
    logic    ready;
    t_addr   frame_address;
    t_status status;
    t_cnt    free_frames;
    t_cnt    total_frames;

    modport source (output valid, frame_address, status, free_frames, total_frames,
                    input ready);
    modport sink   (input valid, frame_address, status, free_frames, total_frames,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/pfsa_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module pfsa_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/page_frame_stack_allocator_unit.sv =====
`default_nettype none

// Free-frame stack allocator for physical page frames.
// i_cmd carries commands (allocate, free, add region); o_res returns exactly one
// beat per command: popped address, status, free and total frame counts.
// The stack of free frame numbers lives in one RAM with a registered read;
// the stack pointer and counts are in flip-flops.
// Completion: free, unused codes, allocate on an empty stack and an unavailable
// region finish in the accepting cycle, allocate after the RAM read, add-region
// after pushing its frames in the fill state (one RAM write per frame).
// The next command is accepted as soon as the current one has finished, even
// while its result still sits in the output register. If that register is
// still full when another result is done, the result is parked and i_cmd stalls
// until o_res takes the waiting beat.
// Reset (synchronous, active low) empties the stack and clears both counts;
// the RAM needs no clearing since only entries below the stack pointer are read.
// A pop never overlaps a write to the same entry, so no forwarding is needed.
module page_frame_stack_allocator_unit #(
    parameter int STACK_DEPTH = 65536,
    parameter int BLOCK_SHIFT = 12
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pfsa_in_if.sink     i_cmd,
    pfsa_out_if.source  o_res
);
    import pfsa_pkg::*;

    localparam int FW = ADDR_W - BLOCK_SHIFT;          // frame number width
    localparam int CW = $clog2(STACK_DEPTH + 1);        // stack pointer width
    localparam int AW = $clog2(STACK_DEPTH);            // RAM index width
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_FILL = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    t_cnt            r_total, n_total;
    logic [FW-1:0]   r_frame, n_frame;
    logic [FW-1:0]   r_left,  n_left;
    t_addr           r_p_addr, n_p_addr;
    t_status         r_p_status, n_p_status;

    logic            r_out_valid;
    t_addr           r_out_addr;
    t_status         r_out_status;
    t_cnt            r_out_free;
    t_cnt            r_out_total;

    logic            in_fire;
    logic            slot_free;
    logic            full;
    logic            done;
    logic            load;
    t_addr           res_addr;
    t_status         res_status;
    t_addr           load_addr;
    t_status         load_status;
    logic [CW+16:0]  cnt_ext;
    logic [CW-1:0]   rd_ptr;

    logic            ram_we;
    logic [FW-1:0]   ram_wdata;
    logic            ram_re;
    logic [FW-1:0]   ram_rdata;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_fire     = i_cmd.valid && i_cmd.ready;
    assign slot_free   = !r_out_valid || o_res.ready;
    assign full        = (r_count == DEPTH_C);
    assign rd_ptr      = r_count - 1'b1;

    // Frame stack storage
    pfsa_ram #(
        .WIDTH (FW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rd_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Command sequencer
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_total    = r_total;
        n_frame    = r_frame;
        n_left     = r_left;
        n_p_addr   = r_p_addr;
        n_p_status = r_p_status;
        ram_we     = 1'b0;
        ram_wdata  = r_frame;
        ram_re     = 1'b0;
        done       = 1'b0;
        res_addr   = '0;
        res_status = STAT_OK;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_cmd.cmd)
                        CMD_ALLOC: begin
                            if (r_count == '0) begin
                                done       = 1'b1;
                                res_status = STAT_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                                ram_re  = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        CMD_FREE: begin
                            done = 1'b1;
                            if (full) begin
                                res_status = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = i_cmd.address[ADDR_W-1:BLOCK_SHIFT];
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_REGION: begin
                            if (i_cmd.region_available) begin
                                n_frame = i_cmd.address[ADDR_W-1:BLOCK_SHIFT];
                                n_left  = i_cmd.region_length[ADDR_W-1:BLOCK_SHIFT];
                                n_state = S_FILL;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                // popped frame arrives from the RAM read register
                done     = 1'b1;
                res_addr = ADDR_W'(ram_rdata) << BLOCK_SHIFT;
            end
            S_FILL: begin
                // one frame pushed per cycle until the region or the stack runs out
                if (r_left == '0) begin
                    done = 1'b1;
                end else if (full) begin
                    done       = 1'b1;
                    res_status = STAT_FULL;
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + 1'b1;
                    n_frame = r_frame + 1'b1;
                    n_left  = r_left - 1'b1;
                    n_total = (r_total == TOTAL_MAX) ? r_total : r_total + 1'b1;
                end
            end
            S_HOLD: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase

        // finished result goes to the output register, or is parked
        if (done) begin
            if (slot_free) begin
                n_state = S_IDLE;
            end else begin
                n_p_addr   = res_addr;
                n_p_status = res_status;
                n_state    = S_HOLD;
            end
        end
    end

    assign load        = slot_free && (done || (r_state == S_HOLD));
    assign load_addr   = done ? res_addr : r_p_addr;
    assign load_status = done ? res_status : r_p_status;
    assign cnt_ext     = (CW+17)'(n_count);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_frame    <= n_frame;
        r_left     <= n_left;
        r_p_addr   <= n_p_addr;
        r_p_status <= n_p_status;
        if (load) begin
            r_out_addr   <= load_addr;
            r_out_status <= load_status;
            r_out_free   <= cnt_ext[CNT_W-1:0];
            r_out_total  <= n_total;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.frame_address = r_out_addr;
    assign o_res.status        = r_out_status;
    assign o_res.free_frames   = r_out_free;
    assign o_res.total_frames  = r_out_total;

endmodule

`default_nettype wire

// ===== rtl/pfsa_checker.sv =====
`default_nettype none

// Port-level checks for the frame allocator
module pfsa_checker (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    i_in_ready,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire pfsa_pkg::t_addr         i_out_addr,
    input wire pfsa_pkg::t_status       i_out_status,
    input wire pfsa_pkg::t_cnt          i_out_free,
    input wire pfsa_pkg::t_cnt          i_out_total
);
    import pfsa_pkg::*;

    logic [2:0] r_pending;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // commands accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 3'(in_beat) - 3'(out_beat);
        end
    end

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_addr)
            && $stable(i_out_status) && $stable(i_out_free) && $stable(i_out_total))
        else $error("result beat changed while stalled");

    // no result without a command behind it, at most two in flight
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || r_pending != 3'd0) && r_pending <= 3'd2)
        else $error("result count does not match command count");

    // empty status only with an empty stack and a zero address
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == STAT_EMPTY |-> i_out_free == '0 && i_out_addr == '0)
        else $error("empty status with frames on the stack");

    // total frame count never decreases from one beat to the next
    a_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat |=> !i_out_valid || i_out_total >= $past(i_out_total))
        else $error("total frame count decreased");

endmodule

bind page_frame_stack_allocator_unit pfsa_checker u_pfsa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_cmd.valid),
    .i_in_ready   (i_cmd.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_out_addr   (o_res.frame_address),
    .i_out_status (o_res.status),
    .i_out_free   (o_res.free_frames),
    .i_out_total  (o_res.total_frames)
);

`default_nettype wire

// ===== tb/sv/page_frame_stack_allocator_unit_checker.sv =====
// Watches the command and result channels of the frame allocator, keeps its own
// copy of the free-frame stack and the counts, and compares every result beat
// against the oldest outstanding prediction.
module page_frame_stack_allocator_unit_checker #(
    parameter int STACK_DEPTH = 65536,
    parameter int BLOCK_SHIFT = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pfsa_in_if   i_cmd,
    pfsa_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);
    import pfsa_pkg::*;

    localparam int FRAME_W    = ADDR_W - BLOCK_SHIFT;
    localparam int PRINT_CAP  = 40;

    typedef logic [FRAME_W-1:0] t_frame;

    typedef struct packed {
        t_addr   frame_address;
        t_status status;
        t_cnt    free_frames;
        t_cnt    total_frames;
    } t_result;

    // Shadow allocator state
    t_frame          free_list [STACK_DEPTH];
    longint unsigned depth_used;
    longint unsigned frames_found;

    t_result expected_q [$];
    int      mismatches    = 0;
    int      pending_beats = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_beats;

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatches++;
    endtask

    function automatic void push_frame(input t_frame f);
        free_list[depth_used] = f;
        depth_used++;
    endfunction

    // Applies one command to the shadow state and returns the beat it must produce
    function automatic t_result predict_command(input t_cmd c, input t_addr a,
                                                input t_addr l, input logic av);
        t_result         r;
        longint unsigned wanted;
        longint unsigned room;
        longint unsigned take;
        t_frame          base;
        r        = '0;
        r.status = STAT_OK;
        case (c)
            CMD_ALLOC: begin
                if (depth_used == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    depth_used--;
                    r.frame_address = t_addr'(free_list[depth_used]) << BLOCK_SHIFT;
                end
            end
            CMD_FREE: begin
                if (depth_used >= STACK_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    push_frame(t_frame'(a >> BLOCK_SHIFT));
                end
            end
            CMD_REGION: begin
                if (av) begin
                    wanted = l >> BLOCK_SHIFT;
                    room   = STACK_DEPTH - depth_used;
                    take   = (wanted < room) ? wanted : room;
                    base   = t_frame'(a >> BLOCK_SHIFT);
                    // frame numbers wrap inside the address space
                    for (longint unsigned k = 0; k < take; k++) begin
                        push_frame(base + t_frame'(k));
                    end
                    if (take < wanted) begin
                        r.status = STAT_FULL;
                    end
                    if (frames_found + take > longint'(TOTAL_MAX)) begin
                        frames_found = TOTAL_MAX;
                    end else begin
                        frames_found += take;
                    end
                end
            end
            default: ;
        endcase
        r.free_frames  = t_cnt'(depth_used);
        r.total_frames = t_cnt'(frames_found);
        return r;
    endfunction

    // Result beats are checked before the new command is predicted: a command
    // accepted at this edge cannot have produced its result yet.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            depth_used   = 0;
            frames_found = 0;
            expected_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.frame_address, i_res.status, i_res.free_frames,
                        i_res.total_frames};
                if (expected_q.size() == 0) begin
                    report_mismatch("result beat with no command outstanding");
                end else begin
                    want = expected_q.pop_front();
                    if (got.frame_address !== want.frame_address) begin
                        report_mismatch($sformatf("frame_address %h, expected %h",
                                                  got.frame_address, want.frame_address));
                    end
                    if (got.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    end
                    if (got.free_frames !== want.free_frames) begin
                        report_mismatch($sformatf("free_frames %0d, expected %0d",
                                                  got.free_frames, want.free_frames));
                    end
                    if (got.total_frames !== want.total_frames) begin
                        report_mismatch($sformatf("total_frames %0d, expected %0d",
                                                  got.total_frames, want.total_frames));
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                expected_q.push_back(predict_command(i_cmd.cmd, i_cmd.address,
                                                     i_cmd.region_length,
                                                     i_cmd.region_available));
            end
        end
        pending_beats = expected_q.size();
    end

endmodule

// ===== tb/sv/page_frame_stack_allocator_unit_tb.sv =====
module page_frame_stack_allocator_unit_tb;
    import pfsa_pkg::*;

    localparam int     STACK_DEPTH = 65536;
    localparam int     BLOCK_SHIFT = 12;
    localparam t_cmd   CMD_UNUSED  = 2'd3;
    localparam t_addr  BLOCK_BYTES = t_addr'(1) << BLOCK_SHIFT;
    localparam t_addr  ALL_ONES    = '1;
    localparam longint CYCLE_LIMIT = 6_000_000;

    logic   i_clk;
    logic   i_rst_n;
    int     fail_count;
    int     pending_beats;
    int     burst_left  = 0;
    longint cycle_count = 0;

    pfsa_in_if  cmd_if ();
    pfsa_out_if res_if ();

    page_frame_stack_allocator_unit #(
        .STACK_DEPTH (STACK_DEPTH),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    page_frame_stack_allocator_unit_checker #(
        .STACK_DEPTH (STACK_DEPTH),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) alloc_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_beats)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_addr rand_addr();
        return t_addr'({$urandom(), $urandom()});
    endfunction

    // Sends one command beat; bursts of random length with random gaps between
    task automatic issue_command(input t_cmd c, input t_addr a, input t_addr l,
                                 input logic av);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 600)
                                                     : $urandom_range(1, 24);
        end
        cmd_if.valid            <= 1'b1;
        cmd_if.cmd              <= c;
        cmd_if.address          <= a;
        cmd_if.region_length    <= l;
        cmd_if.region_available <= av;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Sender pause until every outstanding result beat has been taken
    task automatic hold_until_drained();
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending_beats != 0) @(negedge i_clk);
    endtask

    // Random command; regions are mostly a few frames, huge lengths only where
    // the stack has little room left (or the region is not available)
    task automatic random_command(input int alloc_pct, input int free_pct,
                                  input int region_pct, input bit huge_ok);
        int    pick;
        logic  avail;
        t_addr len;
        pick  = $urandom_range(0, 99);
        avail = ($urandom_range(0, 4) != 0);
        if (!avail || (huge_ok && $urandom_range(0, 1))) begin
            len = rand_addr();
        end else begin
            len = (t_addr'($urandom_range(0, 6)) << BLOCK_SHIFT)
                | (rand_addr() & (BLOCK_BYTES - 1));
        end
        if (pick < alloc_pct) begin
            issue_command(CMD_ALLOC, rand_addr(), len, avail);
        end else if (pick < alloc_pct + free_pct) begin
            issue_command(CMD_FREE, rand_addr(), len, avail);
        end else if (pick < alloc_pct + free_pct + region_pct) begin
            issue_command(CMD_REGION, rand_addr(), len, avail);
        end else begin
            issue_command(CMD_UNUSED, rand_addr(), len, avail);
        end
    endtask

    // Result side: ready on a pattern of its own, with occasional long open runs
    initial begin
        int hold;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 10);
            res_if.ready <= 1'b1;
            repeat (hold) @(negedge i_clk);
            res_if.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    end

    // Stimulus
    initial begin
        i_rst_n                 = 1'b0;
        cmd_if.valid            = 1'b0;
        cmd_if.cmd              = CMD_ALLOC;
        cmd_if.address          = '0;
        cmd_if.region_length    = '0;
        cmd_if.region_available = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty stack, unused code, frees at the address extremes and unaligned
        issue_command(CMD_ALLOC, rand_addr(), rand_addr(), 1'b1);
        issue_command(CMD_UNUSED, rand_addr(), rand_addr(), 1'b1);
        issue_command(CMD_FREE, '0, rand_addr(), 1'b0);
        issue_command(CMD_FREE, ALL_ONES, rand_addr(), 1'b1);
        issue_command(CMD_FREE, 48'h1234_5678_9ABC, '0, 1'b0);
        repeat (4) issue_command(CMD_ALLOC, rand_addr(), rand_addr(), 1'b0);
        // regions: not available, zero frames, just under one block
        issue_command(CMD_REGION, rand_addr(), ALL_ONES, 1'b0);
        issue_command(CMD_REGION, rand_addr(), '0, 1'b1);
        issue_command(CMD_REGION, rand_addr(), BLOCK_BYTES - 1, 1'b1);
        // region that wraps past the top of the address space
        issue_command(CMD_REGION, 48'hFFFF_FFFF_D123, 5 * BLOCK_BYTES + 77, 1'b1);
        repeat (6) issue_command(CMD_ALLOC, rand_addr(), rand_addr(), 1'b1);
        issue_command(CMD_REGION, '0, BLOCK_BYTES, 1'b1);
        issue_command(CMD_FREE, 48'h8000_0000_0000, '0, 1'b0);
        repeat (2) issue_command(CMD_ALLOC, '0, ALL_ONES, 1'b1);
        hold_until_drained();

        // random traffic around an empty stack
        repeat (350) random_command(40, 30, 25, 1'b0);
        hold_until_drained();

        // fill to the top, then push into a full stack
        issue_command(CMD_REGION, rand_addr(), ALL_ONES, 1'b1);
        issue_command(CMD_FREE, rand_addr(), rand_addr(), 1'b1);
        issue_command(CMD_REGION, rand_addr(), 3 * BLOCK_BYTES, 1'b1);
        hold_until_drained();

        // random traffic around a full stack
        repeat (400) random_command(40, 25, 30, 1'b1);
        hold_until_drained();

        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pfsa_pkg.sv
rtl/pfsa_if.sv
rtl/pfsa_ram.sv
rtl/page_frame_stack_allocator_unit.sv
rtl/pfsa_checker.sv
tb/sv/page_frame_stack_allocator_unit_checker.sv
tb/sv/page_frame_stack_allocator_unit_tb.sv
